// ===== sv/period_tachometer_bar_display_unit_macros.svh =====
// Assertion macros shared by the tachometer checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PERIOD_TACHOMETER_BAR_DISPLAY_UNIT_MACROS_SVH
`define PERIOD_TACHOMETER_BAR_DISPLAY_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while reset is asserted
`define PTBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ptbd assertion failed");

// next-cycle implication
`define PTBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ptbd assertion failed");

`endif

// ===== sv/ptbd_pkg.sv =====
// Package for the period tachometer with LED bar display.
// Holds payload structs, FSM state type, register codes and reset values.
// No dependencies.
`default_nettype none

package ptbd_pkg;

	localparam logic [31:0] SPEED_CONSTANT_RST = 32'd794492;
	localparam logic [15:0] BAR_OFFSET_RST     = 16'd57;
	localparam logic [7:0]  BAR_STEP_RST       = 8'd7;
	localparam logic [3:0]  MAX_LEVEL          = 4'd8;

	// configuration register indexes
	localparam logic [1:0] CFG_SPEED_CONSTANT = 2'd0;
	localparam logic [1:0] CFG_BAR_OFFSET     = 2'd1;
	localparam logic [1:0] CFG_BAR_STEP       = 2'd2;

	// request kinds
	localparam logic REQ_EDGE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] capture_time;
	} req_t;

	typedef struct packed {
		logic [31:0] speed;
		logic [7:0]  led_pattern;
		logic        led_updated;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_LEVEL,
		ST_EMIT
	} state_t;

	// level 0..8 to bar; level 0 still lights the first LED
	function automatic logic [7:0] level_pattern(input logic [3:0] level);
		logic [7:0] pat;
		case (level) inside
			4'd0, 4'd1: pat = 8'h01;
			4'd2:       pat = 8'h03;
			4'd3:       pat = 8'h07;
			4'd4:       pat = 8'h0F;
			4'd5:       pat = 8'h1F;
			4'd6:       pat = 8'h3F;
			4'd7:       pat = 8'h7F;
			default:    pat = 8'hFF;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

// ===== sv/period_tachometer_bar_display_unit.sv =====
// Period tachometer with eight-LED bar display, top level.
// Depends on ptbd_pkg.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  ptbd_pkg::req_t
//   rsp       out         rsp_valid/rsp_stall  ptbd_pkg::rsp_t
//   cfg       in          cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Edge item: taken while idle, no result.
// Tick item: restoring divider, one quotient bit per cycle, then a setup
//   state, then the bar level by repeated subtraction, then the result
//   load in ST_EMIT, which waits while the output register is held. A tick
//   with no edge skips divider and level; a zero period skips the divider.
// Reset (arst_n low) restores config defaults, clears FSM and tachometer state.
// A result held by rsp_stall blocks the next tick's load; requests stall while
//   it waits. Edges and the next tick's division go ahead before that.
`default_nettype none

module period_tachometer_bar_display_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire ptbd_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output ptbd_pkg::rsp_t      rsp,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [31:0]    cfg_data
);

	// configuration
	logic [31:0] speed_constant_q;
	logic [15:0] bar_offset_q;
	logic [7:0]  bar_step_q;

	// tachometer state
	logic [31:0] last_capture_q;
	logic [31:0] edge_period_q;
	logic        edge_seen_q;
	logic [7:0]  bar_pattern_q;

	// divider: quot_q starts as the dividend and fills with quotient bits
	logic [31:0] quot_q;
	logic [31:0] rem_q;
	logic [4:0]  bit_cnt_q;

	// level search
	logic [31:0] speed_q;
	logic [15:0] diff_q;
	logic [3:0]  level_q;
	logic        updated_q;

	// output register
	ptbd_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	ptbd_pkg::state_t state_q, state_d;

	logic        req_take;
	logic        rsp_take;
	logic        rsp_load;
	logic        level_stop;
	logic [32:0] rem_shift;
	logic [32:0] rem_sub;
	logic        div_ge;
	logic        speed_in_range;

	assign req_take  = req_valid && !req_stall;
	assign rsp_take  = rsp_valid_q && !rsp_stall;
	assign cfg_ready = 1'b1;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_shift = {rem_q, quot_q[31]};
	assign rem_sub   = rem_shift - {1'b0, edge_period_q};
	assign div_ge    = !rem_sub[32];

	// speed at or below the offset; otherwise level is zero
	assign speed_in_range = (quot_q[31:16] == 16'd0) && (quot_q[15:0] <= bar_offset_q);

	// level search ends at the clamp, when the step no longer fits, or on a zero step
	assign level_stop = (level_q == ptbd_pkg::MAX_LEVEL) || (diff_q < {8'd0, bar_step_q})
		|| (bar_step_q == 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptbd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		rsp_load  = 1'b0;
		unique case (state_q)
			ptbd_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid && req.req_type == ptbd_pkg::REQ_TICK) begin
					if (!edge_seen_q) begin
						state_d = ptbd_pkg::ST_EMIT;
					end else if (edge_period_q == 32'd0) begin
						state_d = ptbd_pkg::ST_PREP;
					end else begin
						state_d = ptbd_pkg::ST_DIV;
					end
				end
			end
			ptbd_pkg::ST_DIV: begin
				if (bit_cnt_q == 5'd0) begin
					state_d = ptbd_pkg::ST_PREP;
				end
			end
			ptbd_pkg::ST_PREP: begin
				state_d = ptbd_pkg::ST_LEVEL;
			end
			ptbd_pkg::ST_LEVEL: begin
				if (level_stop) begin
					state_d = ptbd_pkg::ST_EMIT;
				end
			end
			ptbd_pkg::ST_EMIT: begin
				// output register free, or being emptied this cycle
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ptbd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptbd_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_constant_q <= ptbd_pkg::SPEED_CONSTANT_RST;
			bar_offset_q     <= ptbd_pkg::BAR_OFFSET_RST;
			bar_step_q       <= ptbd_pkg::BAR_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ptbd_pkg::CFG_SPEED_CONSTANT: speed_constant_q <= cfg_data;
				ptbd_pkg::CFG_BAR_OFFSET:     bar_offset_q     <= cfg_data[15:0];
				ptbd_pkg::CFG_BAR_STEP:       bar_step_q       <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// tachometer state: edges record the period, a tick with no edge clears it, ticks after an edge update the bar
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_capture_q <= 32'd0;
			edge_period_q  <= 32'd0;
			edge_seen_q    <= 1'b0;
			bar_pattern_q  <= 8'd0;
		end else begin
			if (req_take && req.req_type == ptbd_pkg::REQ_EDGE) begin
				edge_period_q  <= req.capture_time - last_capture_q;
				last_capture_q <= req.capture_time;
				edge_seen_q    <= 1'b1;
			end else if (req_take && !edge_seen_q) begin
				edge_period_q <= 32'd0;
			end
			if (state_q == ptbd_pkg::ST_LEVEL && level_stop) begin
				bar_pattern_q <= ptbd_pkg::level_pattern(level_q);
				edge_seen_q   <= 1'b0;
			end
		end
	end

	// divider, level and result datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ptbd_pkg::ST_IDLE: begin
				quot_q    <= (edge_period_q == 32'd0) ? 32'd0 : speed_constant_q;
				rem_q     <= 32'd0;
				bit_cnt_q <= 5'd31;
				speed_q   <= 32'd0;
				updated_q <= edge_seen_q;
			end
			ptbd_pkg::ST_DIV: begin
				rem_q     <= div_ge ? rem_sub[31:0] : rem_shift[31:0];
				quot_q    <= {quot_q[30:0], div_ge};
				bit_cnt_q <= bit_cnt_q - 5'd1;
			end
			ptbd_pkg::ST_PREP: begin
				speed_q <= quot_q;
				level_q <= 4'd0;
				diff_q  <= speed_in_range ? (bar_offset_q - quot_q[15:0]) : 16'd0;
			end
			ptbd_pkg::ST_LEVEL: begin
				if (!level_stop) begin
					diff_q  <= diff_q - {8'd0, bar_step_q};
					level_q <= level_q + 4'd1;
				end
			end
			ptbd_pkg::ST_EMIT: begin
			end
			default: begin
			end
		endcase
		if (rsp_load) begin
			rsp_q.speed       <= speed_q;
			rsp_q.led_pattern <= bar_pattern_q;
			rsp_q.led_updated <= updated_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_take) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== sv/ptbd_chk.sv =====
// Port-level checker for the period tachometer, bound to the top level.
// Depends on ptbd_pkg and period_tachometer_bar_display_unit_macros.svh.
`default_nettype none

`include "period_tachometer_bar_display_unit_macros.svh"

module ptbd_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire ptbd_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire ptbd_pkg::rsp_t rsp,
	input wire logic           cfg_valid,
	input wire logic           cfg_ready,
	input wire logic [1:0]     cfg_index,
	input wire logic [31:0]    cfg_data
);

	logic [8:0] pat_inc;
	logic       bar_solid;
	logic       unused_ok;

	assign pat_inc   = {1'b0, rsp.led_pattern} + 9'd1;
	assign bar_solid = rsp.led_pattern[0] && $onehot(pat_inc);
	assign unused_ok = req_valid ^ req_stall ^ req.req_type ^ (|req.capture_time)
		^ (|cfg_index) ^ (|cfg_data);

	// a held item stays offered
	`PTBD_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid)
	// a rewritten bar is a solid run of LEDs from bit 0
	`PTBD_ASSERT_SAME(a_bar_shape, clk, arst_n, rsp_valid && rsp.led_updated, bar_solid)
	// no bar rewrite means no edge, so speed reads zero
	`PTBD_ASSERT_SAME(a_idle_speed, clk, arst_n, rsp_valid && !rsp.led_updated, rsp.speed == 32'd0)
	// configuration is always taken
	`PTBD_ASSERT_SAME(a_cfg_ready, clk, arst_n, cfg_valid || unused_ok, cfg_ready)

endmodule

bind period_tachometer_bar_display_unit ptbd_chk u_ptbd_chk (.*);

`default_nettype wire

// ===== test/tach_reading_checker.sv =====
`timescale 1ns / 1ps
// Checker for the period tachometer: watches request, result and register
// channels, predicts each tick's reading and compares it field by field.
// Depends on ptbd_pkg.
module tach_reading_checker
	import ptbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  rsp_t        rsp,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	// register copies
	logic [31:0] speed_k;
	logic [15:0] offset_now;
	logic [7:0]  step_now;

	// tachometer state
	logic [31:0] prev_capture;
	logic [31:0] period_ticks;
	logic [31:0] speed_now;
	logic        edge_pending;
	logic [7:0]  bar_now;

	rsp_t expected_readings[$];
	rsp_t want;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	task automatic take_request(input req_t item);
		logic [31:0] lvl;
		rsp_t        reading;
		if (item.req_type == REQ_EDGE) begin
			period_ticks = item.capture_time - prev_capture;
			prev_capture = item.capture_time;
			edge_pending = 1'b1;
		end else begin
			speed_now = (period_ticks == 32'd0) ? 32'd0 : speed_k / period_ticks;
			reading.led_updated = edge_pending;
			if (!edge_pending) begin
				// no edge since last tick: clear, bar held
				period_ticks = 32'd0;
				speed_now    = 32'd0;
			end else begin
				lvl = 32'd0;
				if (speed_now <= 32'(offset_now) && step_now != 8'd0)
					lvl = (32'(offset_now) - speed_now) / 32'(step_now);
				if (lvl > MAX_LEVEL)
					lvl = MAX_LEVEL;
				// lowest level still lights one LED
				if (lvl == 32'd0)
					lvl = 32'd1;
				bar_now      = 8'((9'd1 << lvl) - 9'd1);
				edge_pending = 1'b0;
			end
			reading.speed       = speed_now;
			reading.led_pattern = bar_now;
			expected_readings.push_back(reading);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_k      = SPEED_CONSTANT_RST;
			offset_now   = BAR_OFFSET_RST;
			step_now     = BAR_STEP_RST;
			prev_capture = 32'd0;
			period_ticks = 32'd0;
			speed_now    = 32'd0;
			edge_pending = 1'b0;
			bar_now      = 8'd0;
			expected_readings.delete();
		end else begin
			// results first: a result never belongs to an item taken this edge
			if (rsp_valid && !rsp_stall) begin
				if (expected_readings.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected reading, expected none, actual %h/%h/%b",
						$time, rsp.speed, rsp.led_pattern, rsp.led_updated);
				end else begin
					want = expected_readings.pop_front();
					if (rsp.speed !== want.speed) begin
						mismatches++;
						$display("%0t: speed mismatch, expected %h, actual %h",
							$time, want.speed, rsp.speed);
					end
					if (rsp.led_pattern !== want.led_pattern) begin
						mismatches++;
						$display("%0t: led_pattern mismatch, expected %h, actual %h",
							$time, want.led_pattern, rsp.led_pattern);
					end
					if (rsp.led_updated !== want.led_updated) begin
						mismatches++;
						$display("%0t: led_updated mismatch, expected %b, actual %b",
							$time, want.led_updated, rsp.led_updated);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SPEED_CONSTANT: speed_k    = cfg_data;
					CFG_BAR_OFFSET:     offset_now = cfg_data[15:0];
					CFG_BAR_STEP:       step_now   = cfg_data[7:0];
					default: ;
				endcase
			end
			if (req_valid && !req_stall)
				take_request(req);
		end
		outstanding = expected_readings.size();
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the period tachometer with LED bar display: drives
// edge and tick items, register writes and result stalls; checking lives in
// tach_reading_checker. Depends on ptbd_pkg and the block's RTL.
module tb;
	import ptbd_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 64;   // beyond the worst-case tick
	localparam int RANDOM_ITEMS  = 1800;
	localparam int PHASES        = 6;

	// register index that decodes to nothing
	localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_e;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	req_t        req       = '0;
	logic        req_stall;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data  = '0;

	int mismatches;
	int outstanding;

	int          cycle_count = 0;
	int          burst_left  = 0;
	int          sent        = 0;
	int          phase;
	int          pick;
	int          goal;
	int          base_count;
	logic [31:0] enc_clock   = 32'd0;   // last capture time sent

	// shadow of the registers, used only to aim periods at the bar range
	logic [31:0] cur_k    = SPEED_CONSTANT_RST;
	logic [15:0] cur_off  = BAR_OFFSET_RST;
	logic [7:0]  cur_step = BAR_STEP_RST;

	stall_mode_e stall_mode      = STALL_NONE;
	int          stall_mode_left = 0;

	period_tachometer_bar_display_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tach_reading_checker reading_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("period_tachometer_bar_display_unit verification failed");
			$finish;
		end
	end

	// Result-side back-pressure. The mode changes at random times so stalls
	// land on every stage of a tick, with quiet stretches in between.
	always @(posedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode      = stall_mode_e'($urandom_range(0, 3));
			stall_mode_left = $urandom_range(50, 400);
		end else begin
			stall_mode_left--;
		end
		case (stall_mode)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 4) != 0);
			default:     rsp_stall <= ((stall_mode_left % 8) < 3);
		endcase
	end

	// Send one item. Items go out in bursts; between bursts valid drops for
	// a random gap (sometimes none). The payload holds while stalled.
	task automatic push_item(input req_t item);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 3);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		burst_left--;
		sent++;
	endtask

	task automatic send_edge(input logic [31:0] capture);
		push_item('{req_type: REQ_EDGE, capture_time: capture});
		enc_clock = capture;
	endtask

	// capture_time is unused on a tick; random content keeps it honest
	task automatic send_tick();
		push_item('{req_type: REQ_TICK, capture_time: $urandom()});
	endtask

	// Drop valid, wait for every reading, then let the block go fully idle.
	task automatic settle();
		req_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Upper data bits are random: the block must keep only the field width.
	task automatic set_config(input logic [31:0] k, input logic [15:0] off,
			input logic [7:0] step);
		settle();
		write_reg(CFG_SPEED_CONSTANT, k);
		write_reg(CFG_BAR_OFFSET, {16'($urandom()), off});
		write_reg(CFG_BAR_STEP, {24'($urandom()), step});
		cur_k    = k;
		cur_off  = off;
		cur_step = step;
	endtask

	// Period aimed so the speed falls near the bar's range under the current
	// settings; one in five is any 32-bit period.
	function automatic logic [31:0] pick_period();
		logic [31:0] s;
		if ($urandom_range(0, 4) == 0 || cur_k == 32'd0)
			return $urandom();
		s = $urandom_range(0, 32'(cur_off) + 10 * 32'(cur_step) + 2);
		if (s == 32'd0)
			return $urandom();
		if (cur_k / s == 32'd0)
			return 32'd1;
		return cur_k / s + $urandom_range(0, 2);
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed, reset settings (constant 794492, offset 57, step 7) ----
		send_tick();                        // tick right after reset, no edge
		send_edge(32'h0000_0000);           // period 0
		send_tick();                        // zero period: speed 0, no divide
		send_edge(32'hFFFF_FFFF);           // largest period
		send_tick();
		send_edge(32'h0000_0010);           // period wraps through zero
		send_tick();                        // fast: speed above offset
		send_tick();                        // tick without edge: bar held
		send_edge(enc_clock + 32'd13939);   // just under the offset
		send_tick();
		send_edge(enc_clock + 32'd13938);   // at the offset
		send_tick();
		for (pick = 2; pick <= 8; pick += 3) begin
			send_edge(enc_clock + 32'd794492 / (32'd57 - 32'd7 * pick));
			send_tick();
		end
		send_edge(32'h5555_5555);           // back-to-back edges, only the last period counts
		send_edge(32'hAAAA_AAAA);
		send_tick();

		// ---- directed, extreme settings ----
		set_config(32'hFFFF_FFFF, 16'hFFFF, 8'd1);
		send_edge(enc_clock + 32'd1);       // speed far above offset
		send_tick();
		send_edge(enc_clock + 32'hFFFF_FFFF);   // speed 1: level clamps to eight
		send_tick();
		set_config(32'd0, 16'd0, 8'd255);
		write_reg(CFG_UNUSED_INDEX, $urandom());    // ignored write
		send_edge(enc_clock + 32'd77);
		send_tick();
		set_config(32'd5000, 16'd300, 8'd0);    // zero step: level 0
		send_edge(enc_clock + 32'd10);
		send_tick();
		send_edge(enc_clock + 32'd100);
		send_tick();

		// ---- random phases ----
		base_count = sent;
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_config(SPEED_CONSTANT_RST, BAR_OFFSET_RST, BAR_STEP_RST);
				1: set_config(32'hFFFF_FFFF, 16'hFFFF, 8'd255);
				default:
					set_config(
						($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(1000, 2000000),
						($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
							: $urandom_range(0, 400),
						($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
			endcase
			goal = base_count + (phase + 1) * RANDOM_ITEMS / PHASES;
			while (sent < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					// the usual pattern: one edge, then the display tick
					send_edge(enc_clock + pick_period());
					send_tick();
				end else if (pick < 75) begin
					repeat ($urandom_range(2, 4)) send_edge(enc_clock + pick_period());
					send_tick();
				end else if (pick < 85) begin
					send_tick();
				end else if (pick < 95) begin
					send_edge($urandom());
				end else begin
					send_edge(enc_clock);   // repeated capture: zero period
					send_tick();
				end
			end
		end

		settle();
		if (mismatches == 0)
			$display("period_tachometer_bar_display_unit verification clean");
		else
			$display("period_tachometer_bar_display_unit verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/ptbd_pkg.sv
sv/period_tachometer_bar_display_unit.sv
sv/ptbd_chk.sv
test/tach_reading_checker.sv
test/tb.sv
